>>> src/ttpc_pkg.sv
package ttpc_pkg;

   // Input kinds.
   localparam logic [2:0] KIND_TICK       = 3'd0;
   localparam logic [2:0] KIND_GO_TO      = 3'd1;
   localparam logic [2:0] KIND_GO_BY      = 3'd2;
   localparam logic [2:0] KIND_SET_HOME   = 3'd3;
   localparam logic [2:0] KIND_RESET_HOME = 3'd4;
   localparam logic [2:0] KIND_GET        = 3'd5;

   // Motion codes.
   localparam logic [1:0] MOTION_STOP = 2'd0;
   localparam logic [1:0] MOTION_UP   = 2'd1;
   localparam logic [1:0] MOTION_DOWN = 2'd2;

   // Milliseconds per whole unit and the reset value of the home register.
   localparam int unsigned MS_PER_UNIT     = 1000;
   localparam logic [30:0] HOME_DEFAULT_MS = 31'd50000;

   // Reciprocal of 1000 for an unsigned 32-bit dividend: q = (m * DIV_MAGIC) >> DIV_SHIFT.
   localparam logic [28:0] DIV_MAGIC = 29'd274877907;
   localparam int unsigned DIV_SHIFT = 38;

   localparam logic signed [31:0] POS_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] POS_MIN = 32'sh8000_0000;

   // One accepted input transaction.
   typedef struct packed {
      logic [2:0]         kind;
      logic [15:0]        elapsed_ms;
      logic signed [21:0] move_value;
   } in_item_type;

   // Item between the position update and the unit conversion.
   typedef struct packed {
      logic [1:0]         motion;
      logic signed [31:0] position_ms;
      logic               is_tick;
      logic               is_get;
   } mid_item_type;

   // One result transaction.
   typedef struct packed {
      logic [1:0]         motion;
      logic               up_drive;
      logic               down_drive;
      logic               report_valid;
      logic signed [22:0] report_units;
   } out_item_type;

   // Saturate a wide signed sum to the signed 32-bit range.
   function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
      logic signed [31:0] r;
      if (v > 34'(POS_MAX)) begin
         r = POS_MAX;
      end else if (v < 34'(POS_MIN)) begin
         r = POS_MIN;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

>>> src/ttpc_unit_div.sv
module ttpc_unit_div
   import ttpc_pkg::*;
(
   input  logic signed [31:0] position_ms,
   output logic signed [22:0] units
);

   logic        negative;
   logic [31:0] magnitude;
   logic [60:0] product;
   logic [22:0] quotient;

   // Divide the magnitude by a constant reciprocal, then restore the sign so
   // the quotient truncates toward zero. The most negative value has magnitude 2^31.
   always_comb begin
      negative  = position_ms[31];
      magnitude = negative ? 32'(-position_ms) : 32'(position_ms);
      product   = 61'(magnitude) * 61'(DIV_MAGIC);
      quotient  = product[60:DIV_SHIFT];
      units     = negative ? -$signed(quotient) : $signed(quotient);
   end

endmodule

>>> src/timed_travel_position_controller.sv
// Open-loop travel controller that estimates carriage position from drive
// time in milliseconds. Each request transaction carries a kind in req_tuser
// (tick, go to, go by, set home, reset home, get) and yields exactly one
// response transaction with the motion state, the drive outputs, the position
// in whole units and a report flag in rsp_tuser. Driving up lowers the position
// and driving down raises it; the position saturates at the signed 32-bit
// limits. The block accepts one transaction every clock cycle while the response
// side is not stalled; each one passes an input register, the position update
// stage and the divide-by-1000 stage, whose result is registered as the response.
// The home position register is written on the csr channel, which is always
// ready and should only be written while the block is idle.
module timed_travel_position_controller
   import ttpc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // elapsed_ms[15:0], move_value[37:16], zeros
   input  logic [2:0]  req_tuser,   // kind[2:0]

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // motion[1:0], up_drive[2], down_drive[3],
                                    // report_units[26:4], zeros
   output logic        rsp_tuser,   // report_valid[0]

   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [30:0] csr_data
);

   // Pipeline registers.
   logic         in_valid_ff, in_valid_in;
   in_item_type  in_ff, in_in;
   logic         mid_valid_ff, mid_valid_in;
   mid_item_type mid_ff, mid_in;
   logic         out_valid_ff, out_valid_in;
   out_item_type out_ff, out_in;

   // Controller state.
   logic [1:0]         motion_ff, motion_in;
   logic signed [31:0] position_ff, position_in;
   logic signed [31:0] target_ff, target_in;
   logic signed [22:0] last_units_ff, last_units_in;
   logic [30:0]        home_ff, home_in;

   logic out_ready, mid_ready, in_ready;
   logic in_adv, mid_adv;

   // Backward ready chain: a stage takes a new item when it is empty or its
   // item moves on in the same cycle.
   assign out_ready  = !out_valid_ff || rsp_tready;
   assign mid_adv    = mid_valid_ff && out_ready;
   assign mid_ready  = !mid_valid_ff || out_ready;
   assign in_adv     = in_valid_ff && mid_ready;
   assign in_ready   = !in_valid_ff || mid_ready;
   assign req_tready = in_ready;
   assign csr_ready  = 1'b1;

   // Capture the request transaction.
   always_comb begin
      in_valid_in = in_valid_ff;
      in_in       = in_ff;
      if (in_ready) begin
         in_valid_in      = req_tvalid;
         in_in.kind       = req_tuser;
         in_in.elapsed_ms = req_tdata[15:0];
         in_in.move_value = $signed(req_tdata[37:16]);
      end
   end

   // Position update stage.
   logic signed [33:0] pos_x, elapsed_x, move_x;
   logic signed [31:0] run_down, run_up, goto_target, goby_target, home_pos;
   logic signed [31:0] aim_target, aim_pos;
   logic               do_aim, is_tick, is_get;

   always_comb begin
      pos_x       = 34'(position_ff);
      elapsed_x   = $signed({18'd0, in_ff.elapsed_ms});
      move_x      = 34'(in_ff.move_value) * 34'sd1000;
      run_up      = sat32(pos_x - elapsed_x);
      run_down    = sat32(pos_x + elapsed_x);
      goto_target = move_x[31:0];
      goby_target = sat32(pos_x + move_x);
      home_pos    = $signed({1'b0, home_ff});

      motion_in   = motion_ff;
      position_in = position_ff;
      target_in   = target_ff;
      aim_target  = target_ff;
      aim_pos     = position_ff;
      do_aim      = 1'b0;
      is_tick     = 1'b0;
      is_get      = 1'b0;

      unique case (in_ff.kind)
         KIND_TICK: begin
            is_tick = 1'b1;
            if (motion_ff == MOTION_UP) begin
               position_in = run_up;
               if (run_up <= target_ff) motion_in = MOTION_STOP;
            end else if (motion_ff == MOTION_DOWN) begin
               position_in = run_down;
               if (run_down >= target_ff) motion_in = MOTION_STOP;
            end
         end
         KIND_GO_TO: begin
            do_aim     = 1'b1;
            aim_target = goto_target;
         end
         KIND_GO_BY: begin
            do_aim     = 1'b1;
            aim_target = goby_target;
         end
         KIND_SET_HOME: begin
            position_in = '0;
         end
         KIND_RESET_HOME: begin
            position_in = home_pos;
            do_aim      = 1'b1;
            aim_target  = '0;
            aim_pos     = home_pos;
         end
         KIND_GET: begin
            is_get = 1'b1;
         end
         default: begin
         end
      endcase

      // Aim at the new target; an equal target keeps the current motion.
      if (do_aim) begin
         target_in = aim_target;
         if (aim_pos > aim_target) begin
            motion_in = MOTION_UP;
         end else if (aim_pos < aim_target) begin
            motion_in = MOTION_DOWN;
         end
      end

      mid_valid_in = mid_ready ? in_valid_ff : mid_valid_ff;
      mid_in       = mid_ff;
      if (in_adv) begin
         mid_in.motion      = motion_in;
         mid_in.position_ms = position_in;
         mid_in.is_tick     = is_tick;
         mid_in.is_get      = is_get;
      end
   end

   // Unit conversion and change report stage.
   logic signed [22:0] mid_units;

   ttpc_unit_div u_unit_div (
      .position_ms (mid_ff.position_ms),
      .units       (mid_units)
   );

   always_comb begin
      last_units_in = last_units_ff;
      out_valid_in  = out_ready ? mid_valid_ff : out_valid_ff;
      out_in        = out_ff;
      if (mid_adv) begin
         out_in.motion       = mid_ff.motion;
         out_in.up_drive     = (mid_ff.motion == MOTION_UP);
         out_in.down_drive   = (mid_ff.motion == MOTION_DOWN);
         out_in.report_units = mid_units;
         out_in.report_valid = mid_ff.is_get
                               || (mid_ff.is_tick && (mid_units != last_units_ff));
         if (mid_ff.is_tick) last_units_in = mid_units;
      end
   end

   // Configuration write.
   always_comb begin
      home_in = home_ff;
      if (csr_valid) home_in = csr_data;
   end

   // Registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         mid_valid_ff  <= 1'b0;
         out_valid_ff  <= 1'b0;
         motion_ff     <= MOTION_STOP;
         position_ff   <= '0;
         target_ff     <= '0;
         last_units_ff <= '0;
         home_ff       <= HOME_DEFAULT_MS;
      end else begin
         in_valid_ff   <= in_valid_in;
         mid_valid_ff  <= mid_valid_in;
         out_valid_ff  <= out_valid_in;
         if (in_adv) begin
            motion_ff   <= motion_in;
            position_ff <= position_in;
            target_ff   <= target_in;
         end
         last_units_ff <= last_units_in;
         home_ff       <= home_in;
      end
   end

   always_ff @(posedge clock) begin
      in_ff  <= in_in;
      mid_ff <= mid_in;
      out_ff <= out_in;
   end

   // Response ports.
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {5'd0, out_ff.report_units, out_ff.down_drive,
                        out_ff.up_drive, out_ff.motion};
   assign rsp_tuser  = out_ff.report_valid;

   // A stalled middle item stays put until the response register frees up.
   a_mid_hold: assert property (@(posedge clock) disable iff (reset)
      mid_valid_ff && !out_ready |=> mid_valid_ff && $stable(mid_ff))
      else $error("middle stage item changed while stalled");

   // A tick never starts motion from a stop.
   a_tick_no_start: assert property (@(posedge clock) disable iff (reset)
      in_adv && in_ff.kind == KIND_TICK && motion_ff == MOTION_STOP
      |=> motion_ff == MOTION_STOP)
      else $error("tick started the drive");

   // The last compared units change only when a tick leaves the middle stage.
   a_units_on_tick: assert property (@(posedge clock) disable iff (reset)
      !(mid_adv && mid_ff.is_tick) |=> $stable(last_units_ff))
      else $error("last compared units changed without a tick");

   // A get always produces a flagged report.
   a_get_reports: assert property (@(posedge clock) disable iff (reset)
      mid_adv && mid_ff.is_get |=> out_valid_ff && out_ff.report_valid)
      else $error("get did not produce a report");

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top
   import ttpc_pkg::*;
();

   localparam int unsigned CYCLE_LIMIT       = 1_000_000;
   localparam int unsigned DRAIN_CYCLES      = 10;
   localparam int unsigned LONG_HOLD_CYCLES  = 400;
   localparam int unsigned ITEMS_PER_SETTING = 65;
   localparam int unsigned DESCENT_TICKS     = 780;
   localparam int unsigned FLOOR_TICKS       = 4;
   localparam int unsigned PRINT_CAP         = 40;

   localparam logic [15:0]        ELAPSED_MAX = 16'hFFFF;
   localparam logic signed [21:0] MOVE_MAX    = 22'sh1F_FFFF;
   localparam logic signed [21:0] MOVE_MIN    = 22'sh20_0000;
   localparam logic [30:0]        HOME_MAX    = 31'h7FFF_FFFF;

   // Kinds outside the command set; the block must leave its state alone.
   localparam logic [2:0] KIND_SPARE_LO = 3'd6;
   localparam logic [2:0] KIND_SPARE_HI = 3'd7;

   // Position tracker: mirrors the controller state and queues expected responses.
   class travel_scoreboard;
      logic [30:0]        home_ms;
      logic [1:0]         motion;
      logic signed [31:0] pos_ms;
      logic signed [31:0] target_ms;
      logic signed [31:0] last_pos_ms;
      out_item_type       expected_rsp[$];
      int unsigned        mismatches;
      int unsigned        responses;
      int unsigned        reports;
      int unsigned        at_limit;

      function new();
         home_ms     = HOME_DEFAULT_MS;
         motion      = MOTION_STOP;
         pos_ms      = '0;
         target_ms   = '0;
         last_pos_ms = '0;
         mismatches  = 0;
         responses   = 0;
         reports     = 0;
         at_limit    = 0;
      endfunction

      function void write_home(input logic [30:0] value);
         home_ms = value;
      endfunction

      function logic signed [31:0] clamp_pos(input longint value);
         if (value > longint'(POS_MAX)) begin
            return POS_MAX;
         end else if (value < longint'(POS_MIN)) begin
            return POS_MIN;
         end
         return value[31:0];
      endfunction

      // Whole units, truncated toward zero.
      function longint whole_units(input logic signed [31:0] p);
         return longint'(p) / longint'(MS_PER_UNIT);
      endfunction

      // A target equal to the position leaves the motion as it was.
      function void aim_at(input logic signed [31:0] t);
         target_ms = t;
         if (pos_ms > target_ms) begin
            motion = MOTION_UP;
         end
         if (pos_ms < target_ms) begin
            motion = MOTION_DOWN;
         end
      endfunction

      function void note_request(input logic [2:0] kind, input logic [15:0] elapsed,
                                 input logic signed [21:0] move);
         logic         report;
         out_item_type want;
         report = 1'b0;
         case (kind)
            KIND_TICK: begin
               // Driving up lowers the position, driving down raises it.
               if (motion == MOTION_UP) begin
                  pos_ms = clamp_pos(longint'(pos_ms) - longint'(elapsed));
                  if (pos_ms <= target_ms) begin
                     motion = MOTION_STOP;
                  end
               end else if (motion == MOTION_DOWN) begin
                  pos_ms = clamp_pos(longint'(pos_ms) + longint'(elapsed));
                  if (pos_ms >= target_ms) begin
                     motion = MOTION_STOP;
                  end
               end
               report      = whole_units(pos_ms) != whole_units(last_pos_ms);
               last_pos_ms = pos_ms;
            end
            KIND_GO_TO: begin
               aim_at(clamp_pos(longint'(move) * longint'(MS_PER_UNIT)));
            end
            KIND_GO_BY: begin
               aim_at(clamp_pos(longint'(pos_ms) + longint'(move) * longint'(MS_PER_UNIT)));
            end
            KIND_SET_HOME: begin
               pos_ms = '0;
            end
            KIND_RESET_HOME: begin
               pos_ms = $signed({1'b0, home_ms});
               aim_at('0);
            end
            KIND_GET: begin
               report = 1'b1;
            end
            default: begin
            end
         endcase
         if (pos_ms == POS_MAX || pos_ms == POS_MIN) begin
            at_limit++;
         end
         want.motion       = motion;
         want.up_drive     = motion == MOTION_UP;
         want.down_drive   = motion == MOTION_DOWN;
         want.report_valid = report;
         want.report_units = 23'(whole_units(pos_ms));
         expected_rsp.push_back(want);
      endfunction

      // One line per mismatch; quiet after the first screenful, the count keeps going.
      task report_mismatch(input string what);
         if (mismatches < PRINT_CAP) begin
            $display("ERROR at %0t: %s", $realtime, what);
         end
         mismatches++;
      endtask

      task check_response(input logic [31:0] data, input logic user);
         out_item_type want;
         responses++;
         if (expected_rsp.size() == 0) begin
            report_mismatch($sformatf("response %0d arrived with nothing expected", responses));
            return;
         end
         want = expected_rsp.pop_front();
         if (data[1:0] !== want.motion) begin
            report_mismatch($sformatf("response %0d motion %0d, expected %0d",
                                      responses, data[1:0], want.motion));
         end
         if (data[2] !== want.up_drive) begin
            report_mismatch($sformatf("response %0d up_drive %0b, expected %0b",
                                      responses, data[2], want.up_drive));
         end
         if (data[3] !== want.down_drive) begin
            report_mismatch($sformatf("response %0d down_drive %0b, expected %0b",
                                      responses, data[3], want.down_drive));
         end
         if (data[26:4] !== want.report_units) begin
            report_mismatch($sformatf("response %0d report_units %0d, expected %0d",
                                      responses, $signed(data[26:4]), want.report_units));
         end
         if (user !== want.report_valid) begin
            report_mismatch($sformatf("response %0d report_valid %0b, expected %0b",
                                      responses, user, want.report_valid));
         end
         if (user === 1'b1) begin
            reports++;
         end
      endtask
   endclass

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata  = '0;   // elapsed_ms[15:0], move_value[37:16], zeros
   logic [2:0]  req_tuser  = '0;   // kind[2:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;         // motion[1:0], up_drive[2], down_drive[3],
                                   // report_units[26:4], zeros
   logic        rsp_tuser;         // report_valid[0]
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [30:0] csr_data   = '0;

   travel_scoreboard tracker = new();

   int unsigned cycle_count        = 0;
   int unsigned burst_left         = 0;
   bit          gaps_enabled       = 1'b1;
   int unsigned commands_sent      = 0;
   int unsigned spare_kinds_sent   = 0;
   int unsigned home_writes        = 0;
   int unsigned long_hold_requests = 0;
   int unsigned long_holds_done    = 0;
   int unsigned hold_left          = 0;
   int unsigned stall_mode         = 0;
   int unsigned mode_left          = 0;

   timed_travel_position_controller u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   // Run limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d responses outstanding",
                  cycle_count, tracker.expected_rsp.size());
         $display("tb_top failed");
         $finish;
      end
   end

   // Response transactions are checked as they are accepted.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         tracker.check_response(rsp_tdata, rsp_tuser);
      end
   end

   // Response side: a stall pattern that changes mode now and then, plus a long
   // hold-off when one is requested, which lets the block fill up.
   always @(negedge clock) begin
      if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (long_holds_done != long_hold_requests) begin
         long_holds_done <= long_holds_done + 1;
         hold_left       <= LONG_HOLD_CYCLES;
         rsp_tready      <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            stall_mode <= $urandom_range(3, 0);
            mode_left  <= $urandom_range(120, 20);
         end else begin
            mode_left <= mode_left - 1;
         end
         case (stall_mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= 1'($urandom_range(1, 0));
            2: rsp_tready <= $urandom_range(3, 0) != 0;
            default: rsp_tready <= $urandom_range(3, 0) == 0;
         endcase
      end
   end

   // Offer one request transaction, after a gap when the current burst is used up.
   task automatic send_item(input logic [2:0] kind, input logic [15:0] elapsed,
                            input logic signed [21:0] move);
      int unsigned gap;
      gap = 0;
      if (gaps_enabled && burst_left == 0) begin
         gap        = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 1);
         burst_left = $urandom_range(24, 1);
      end
      @(negedge clock);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, move, elapsed};
      req_tuser  <= kind;
      do begin
         @(posedge clock);
      end while (!req_tready);
      tracker.note_request(kind, elapsed, move);
      if (burst_left != 0) begin
         burst_left--;
      end
      if (kind == KIND_SPARE_LO || kind == KIND_SPARE_HI) begin
         spare_kinds_sent++;
      end else begin
         commands_sent++;
      end
   endtask

   // Stop offering and wait until every response is back and the pipe is empty.
   task automatic wait_idle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (tracker.expected_rsp.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_home(input logic [30:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do begin
         @(posedge clock);
      end while (!csr_ready);
      tracker.write_home(value);
      home_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic signed [21:0] near_units();
      return 22'(int'($urandom_range(60, 0)) - 30);
   endfunction

   function automatic logic [15:0] short_elapsed();
      return ($urandom_range(7, 0) == 0) ? 16'd0 : 16'($urandom_range(4000, 1));
   endfunction

   // Random traffic: mostly a move followed by ticks that carry it out,
   // mixed with home commands, reads, spare kinds and full-range values.
   task automatic run_random(input int unsigned count);
      int unsigned goal;
      int unsigned choice;
      int unsigned ticks;
      goal = commands_sent + count;
      while (commands_sent < goal) begin
         choice = $urandom_range(99, 0);
         if (choice < 55) begin
            send_item($urandom_range(1, 0) ? KIND_GO_TO : KIND_GO_BY, 16'($urandom),
                      near_units());
            ticks = $urandom_range(12, 1);
            repeat (ticks) begin
               if ($urandom_range(9, 0) == 0) begin
                  send_item(KIND_GET, 16'($urandom), 22'($urandom));
               end else begin
                  send_item(KIND_TICK, short_elapsed(), 22'($urandom));
               end
            end
         end else if (choice < 63) begin
            send_item(KIND_GET, 16'($urandom), 22'($urandom));
         end else if (choice < 70) begin
            send_item(KIND_SET_HOME, 16'($urandom), 22'($urandom));
         end else if (choice < 76) begin
            send_item(KIND_RESET_HOME, 16'($urandom), 22'($urandom));
            ticks = $urandom_range(4, 1);
            repeat (ticks) send_item(KIND_TICK, short_elapsed(), 22'($urandom));
         end else if (choice < 84) begin
            send_item(3'($urandom_range(7, 0)), 16'($urandom), 22'($urandom));
         end else if (choice < 92) begin
            send_item($urandom_range(1, 0) ? KIND_GO_TO : KIND_GO_BY, 16'($urandom),
                      22'($urandom));
         end else begin
            send_item(KIND_TICK, 16'($urandom), 22'($urandom));
         end
      end
   endtask

   initial begin
      logic [30:0] home_settings [5];
      home_settings[0] = 31'd0;
      home_settings[1] = HOME_MAX;
      home_settings[2] = 31'($urandom);
      home_settings[3] = 31'd1500;
      home_settings[4] = HOME_DEFAULT_MS;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part with the home register at its reset value.
      send_item(KIND_GET, ELAPSED_MAX, MOVE_MAX);
      send_item(KIND_TICK, 16'd0, MOVE_MIN);
      send_item(KIND_GO_TO, 16'd0, 22'sd5);
      send_item(KIND_TICK, ELAPSED_MAX, 22'sd0);
      // Target equal to the position: stays stopped.
      send_item(KIND_GO_BY, ELAPSED_MAX, 22'sd0);
      send_item(KIND_GO_TO, 16'd0, -22'sd3);
      send_item(KIND_TICK, 16'd1000, 22'sd0);
      // Set home while moving keeps the motion; the unit change shows on the next tick.
      send_item(KIND_SET_HOME, 16'd0, 22'sd0);
      send_item(KIND_TICK, 16'd0, 22'sd0);
      send_item(KIND_TICK, 16'd3000, 22'sd0);
      send_item(KIND_SPARE_LO, ELAPSED_MAX, -22'sd1);
      send_item(KIND_SPARE_HI, ELAPSED_MAX, -22'sd1);
      send_item(KIND_RESET_HOME, 16'd0, 22'sd0);
      // Go to the current position while driving up keeps driving up.
      send_item(KIND_GO_TO, 16'd0, 22'sd50);
      send_item(KIND_GO_TO, 16'd0, MOVE_MAX);
      send_item(KIND_GO_TO, 16'd0, MOVE_MIN);
      send_item(KIND_TICK, ELAPSED_MAX, 22'sd0);
      send_item(KIND_GO_BY, 16'd0, MOVE_MIN);
      send_item(KIND_GO_BY, 16'd0, MOVE_MAX);
      send_item(KIND_GET, 16'd0, 22'sd0);
      wait_idle();

      // Home near the top of the range: a tick and a go-by saturate high.
      write_home(HOME_MAX - 31'd1000);
      send_item(KIND_RESET_HOME, 16'd0, 22'sd0);
      send_item(KIND_GO_BY, 16'd0, 22'sd1);
      send_item(KIND_TICK, ELAPSED_MAX, 22'sd0);
      send_item(KIND_GO_BY, 16'd0, MOVE_MAX);
      send_item(KIND_TICK, 16'd0, 22'sd0);
      wait_idle();

      // Random part over several home settings, the extremes among them.
      for (int i = 0; i < 5; i++) begin
         write_home(home_settings[i]);
         if (i == 1) begin
            long_hold_requests++;
         end
         run_random(ITEMS_PER_SETTING);
         wait_idle();
      end

      // Descent far enough below zero that a go-by saturates the target at
      // the low limit.
      gaps_enabled = 1'b0;
      send_item(KIND_SET_HOME, 16'd0, 22'sd0);
      send_item(KIND_GO_TO, 16'd0, MOVE_MIN);
      repeat (DESCENT_TICKS) send_item(KIND_TICK, ELAPSED_MAX, 22'sd0);
      send_item(KIND_GO_BY, 16'd0, MOVE_MIN);
      repeat (FLOOR_TICKS) send_item(KIND_TICK, ELAPSED_MAX, 22'sd0);
      send_item(KIND_GO_BY, 16'd0, -22'sd1);
      send_item(KIND_GET, 16'd0, 22'sd0);
      wait_idle();

      if (tracker.expected_rsp.size() != 0) begin
         tracker.report_mismatch($sformatf("%0d expected responses never arrived",
                                           tracker.expected_rsp.size()));
      end
      $display("Covered %0d commands and %0d spare kinds under %0d home settings;",
               commands_sent, spare_kinds_sent, home_writes);
      $display("checked %0d responses, %0d with a report, %0d at a position limit.",
               tracker.responses, tracker.reports, tracker.at_limit);
      if (tracker.mismatches == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

endmodule

>>> sim.f
src/ttpc_pkg.sv
src/ttpc_unit_div.sv
src/timed_travel_position_controller.sv
tb/tb_top.sv
